// ===== src/ism_pkg.sv =====
// Shared types and constants for the interval subscription matcher.
// Holds the token that travels down the cell chain; no dependencies.
package ism_pkg;

   localparam int MAX_SUBS   = 64;
   localparam int NUM_ATTRS  = 16;
   localparam int VALUE_BITS = 20;

   localparam int ATTR_W   = 4;
   localparam int BOUND_W  = 20;
   localparam int INDEX_W  = 6;
   localparam int MASK_W   = 64;
   localparam int COUNT_W  = 7;

   localparam int ROW_W  = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1;
   localparam int CNT_W  = $clog2(MAX_SUBS + 1);
   localparam int AIDX_W = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_EVENT  = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic                  last;
      logic                  attr_ok;
      logic [AIDX_W-1:0]     aidx;
      logic [VALUE_BITS-1:0] lo;
      logic [VALUE_BITS-1:0] hi;
      logic                  we;
      logic                  first;
      logic [ROW_W-1:0]      target;
      logic                  status;
      logic [INDEX_W-1:0]    sub_index;
      logic [MAX_SUBS-1:0]   mask;
      logic [CNT_W-1:0]      count;
   } tok_type;

endpackage

// ===== src/ism_head.sv =====
// Entry stage of the matcher: subscription counter, overflow flag and token build.
// Depends on ism_pkg.
module ism_head (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       req_type,
   input  logic [ism_pkg::ATTR_W-1:0]  req_attribute,
   input  logic [ism_pkg::BOUND_W-1:0] req_low_bound,
   input  logic [ism_pkg::BOUND_W-1:0] req_high_bound,
   input  logic [ism_pkg::BOUND_W-1:0] req_event_value,
   input  logic                       req_last,
   output ism_pkg::tok_type           tok
);
   import ism_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic             open_ff, open_in;
   logic             full;
   logic             attr_ok;

   assign full    = (32'(count_ff) >= 32'(MAX_SUBS));
   assign attr_ok = (32'(req_attribute) < 32'(NUM_ATTRS));

   always_comb begin
      tok           = '0;
      tok.kind      = req_type;
      tok.last      = req_last;
      tok.attr_ok   = attr_ok;
      tok.aidx      = AIDX_W'(req_attribute);
      tok.first     = !open_ff;
      tok.target    = ROW_W'(count_ff);
      tok.mask      = '0;
      tok.count     = '0;
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      open_in       = open_ff;
      unique case (req_type)
         KIND_INSERT: begin
            tok.lo = req_low_bound[VALUE_BITS-1:0];
            tok.hi = req_high_bound[VALUE_BITS-1:0];
            tok.we = !full;
            if (full) begin
               overflow_in = 1'b1;
            end
            if (req_last) begin
               if (overflow_ff || full) begin
                  tok.status  = STATUS_FULL;
                  tok.sub_index = '0;
                  overflow_in = 1'b0;
               end else begin
                  tok.status    = STATUS_OK;
                  tok.sub_index = INDEX_W'(count_ff);
                  count_in      = count_ff + 1'b1;
               end
            end
            open_in = !req_last;
         end
         KIND_EVENT: begin
            tok.lo = req_event_value[VALUE_BITS-1:0];
            tok.hi = '0;
            tok.we = 1'b0;
         end
         default: begin
            tok.we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         open_ff     <= 1'b0;
      end else if (accept) begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         open_ff     <= open_in;
      end
   end

endmodule

// ===== src/ism_cell.sv =====
// One subscription row: bounds per attribute, falsified mark, stored flag.
// Takes a token from its left neighbor and hands it on each cycle that the chain advances. Depends on ism_pkg.
module ism_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  ism_pkg::tok_type tok_in,
   output logic             out_valid,
   output ism_pkg::tok_type tok_out
);
   import ism_pkg::*;

   logic [VALUE_BITS-1:0] lo_ff [NUM_ATTRS];
   logic [VALUE_BITS-1:0] hi_ff [NUM_ATTRS];
   logic [NUM_ATTRS-1:0]  present_ff, present_in;
   logic                  stored_ff, stored_in;
   logic                  mark_ff, mark_in;
   logic                  valid_ff;
   tok_type               tok_ff, tok_nx;

   logic                  row_hit;
   logic                  pres_cur;
   logic [VALUE_BITS-1:0] lo_cur, hi_cur;
   logic [VALUE_BITS-1:0] lo_in, hi_in;
   logic                  miss;
   logic                  match_bit;
   logic                  wr_bounds;

   assign lo_cur   = lo_ff[tok_in.aidx];
   assign hi_cur   = hi_ff[tok_in.aidx];
   assign pres_cur = present_ff[tok_in.aidx];

   assign row_hit = in_valid && (tok_in.kind == KIND_INSERT) && tok_in.we &&
                    (tok_in.target == '0);

   always_comb begin
      present_in = present_ff;
      stored_in  = stored_ff;
      mark_in    = mark_ff;
      lo_in      = tok_in.lo;
      hi_in      = tok_in.hi;
      wr_bounds  = 1'b0;
      miss       = 1'b0;
      match_bit  = 1'b0;
      tok_nx     = tok_in;
      if (in_valid) begin
         unique case (tok_in.kind)
            KIND_INSERT: begin
               tok_nx.target = tok_in.target - 1'b1;
               if (row_hit) begin
                  tok_nx.we = 1'b0;
                  if (tok_in.first) begin
                     present_in = '0;
                  end
                  if (tok_in.attr_ok) begin
                     wr_bounds = 1'b1;
                     present_in[tok_in.aidx] = 1'b1;
                     if (!tok_in.first && pres_cur) begin
                        if (lo_cur > tok_in.lo) begin
                           lo_in = lo_cur;
                        end
                        if (hi_cur < tok_in.hi) begin
                           hi_in = hi_cur;
                        end
                     end
                  end
                  if (tok_in.last) begin
                     stored_in = 1'b1;
                  end
               end
            end
            KIND_EVENT: begin
               miss = stored_ff && tok_in.attr_ok && pres_cur &&
                      ((tok_in.lo < lo_cur) || (tok_in.lo > hi_cur));
               if (tok_in.last) begin
                  match_bit    = stored_ff && !(mark_ff || miss);
                  mark_in      = 1'b0;
                  tok_nx.mask  = (tok_in.mask >> 1) |
                                 (MAX_SUBS'(match_bit) << (MAX_SUBS - 1));
                  tok_nx.count = tok_in.count + CNT_W'(match_bit);
               end else begin
                  mark_in = mark_ff || miss;
               end
            end
            default: begin
               tok_nx = tok_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff <= 1'b0;
         mark_ff   <= 1'b0;
         valid_ff  <= 1'b0;
      end else if (adv) begin
         stored_ff <= stored_in;
         mark_ff   <= mark_in;
         valid_ff  <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tok_ff     <= tok_nx;
         present_ff <= present_in;
         if (wr_bounds) begin
            lo_ff[tok_in.aidx] <= lo_in;
            hi_ff[tok_in.aidx] <= hi_in;
         end
      end
   end

   assign out_valid = valid_ff;
   assign tok_out   = tok_ff;

endmodule

// ===== src/interval_subscription_matcher.sv =====
// Top level of the interval subscription matcher: entry stage and a row of subscription cells.
// Depends on ism_pkg, ism_head and ism_cell.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_ready | type, attribute, bounds, event value, last
//   rsp_    | out       | rsp_valid / rsp_ready | kind, status, index, match mask and count
//
// One beat enters per cycle while req_ready is high; each beat walks the chain of MAX_SUBS
// cells, one cell a cycle while the chain advances, and its result leaves from the last cell.
// The last cell's register is the output register: while a result waits there, the
// whole chain holds and req_ready drops. Beats without a result drop off at the end.
// Reset clears the subscription count, the marks and the stored flags; no clearing pass.
module interval_subscription_matcher (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic [ism_pkg::ATTR_W-1:0]  req_attribute,
   input  logic [ism_pkg::BOUND_W-1:0] req_low_bound,
   input  logic [ism_pkg::BOUND_W-1:0] req_high_bound,
   input  logic [ism_pkg::BOUND_W-1:0] req_event_value,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_result_kind,
   output logic                        rsp_status,
   output logic [ism_pkg::INDEX_W-1:0] rsp_sub_index,
   output logic [ism_pkg::MASK_W-1:0]  rsp_match_mask,
   output logic [ism_pkg::COUNT_W-1:0] rsp_match_count
);
   import ism_pkg::*;

   logic    adv;
   logic    accept;
   logic    chain_valid [MAX_SUBS+1];
   tok_type chain_tok   [MAX_SUBS+1];

   assign adv       = !(rsp_valid && !rsp_ready);
   assign req_ready = adv;
   assign accept    = req_valid && adv;

   ism_head u_head (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_type        (req_type),
      .req_attribute   (req_attribute),
      .req_low_bound   (req_low_bound),
      .req_high_bound  (req_high_bound),
      .req_event_value (req_event_value),
      .req_last        (req_last),
      .tok             (chain_tok[0])
   );

   assign chain_valid[0] = accept;

   for (genvar i = 0; i < MAX_SUBS; i++) begin : g_cell
      ism_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (chain_valid[i]),
         .tok_in    (chain_tok[i]),
         .out_valid (chain_valid[i+1]),
         .tok_out   (chain_tok[i+1])
      );
   end

   assign rsp_valid       = chain_valid[MAX_SUBS] && chain_tok[MAX_SUBS].last;
   assign rsp_result_kind = chain_tok[MAX_SUBS].kind;
   assign rsp_status      = chain_tok[MAX_SUBS].status;
   assign rsp_sub_index   = chain_tok[MAX_SUBS].sub_index;
   assign rsp_match_mask  = MASK_W'(chain_tok[MAX_SUBS].mask);
   assign rsp_match_count = COUNT_W'(chain_tok[MAX_SUBS].count);

endmodule

// ===== tb/sv/tb_interval_subscription_matcher.sv =====
// Self-checking testbench for interval_subscription_matcher: subscription inserts and event beats,
// with each result compared against a behavioral copy of the subscription table.
// Depends on ism_pkg and the interval_subscription_matcher RTL.
module tb_interval_subscription_matcher;
   import ism_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;
   localparam int BEAT_GOAL   = 720;
   localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

   typedef struct packed {
      logic               kind;
      logic               status;
      logic [INDEX_W-1:0] index;
      logic [MASK_W-1:0]  mask;
      logic [COUNT_W-1:0] count;
   } outcome_type;

   class interval_book_type;
      logic [VALUE_BITS-1:0] lo_tab [MAX_SUBS][NUM_ATTRS];
      logic [VALUE_BITS-1:0] hi_tab [MAX_SUBS][NUM_ATTRS];
      bit                    present [MAX_SUBS][NUM_ATTRS];
      bit [MAX_SUBS-1:0]     falsified;
      int                    stored;
      bit                    overflow;
      outcome_type           due_outcomes[$];
      int                    errors;

      function void absorb_request(logic kind, logic [ATTR_W-1:0] attr,
                                   logic [VALUE_BITS-1:0] lo, logic [VALUE_BITS-1:0] hi,
                                   logic [VALUE_BITS-1:0] val, logic last);
         outcome_type       o;
         bit [MAX_SUBS-1:0] live;
         o = '0;
         if (kind == KIND_INSERT) begin
            if (stored >= MAX_SUBS) begin
               overflow = 1'b1;
            end else if (attr < NUM_ATTRS) begin
               if (present[stored][attr]) begin
                  if (lo > lo_tab[stored][attr]) lo_tab[stored][attr] = lo;
                  if (hi < hi_tab[stored][attr]) hi_tab[stored][attr] = hi;
               end else begin
                  lo_tab[stored][attr] = lo;
                  hi_tab[stored][attr] = hi;
                  present[stored][attr] = 1'b1;
               end
            end
            if (!last) return;
            o.kind = KIND_INSERT;
            if (overflow || stored >= MAX_SUBS) begin
               o.status = STATUS_FULL;
               overflow = 1'b0;
            end else begin
               o.status = STATUS_OK;
               o.index  = stored[INDEX_W-1:0];
               stored++;
            end
            due_outcomes = {due_outcomes, o};
            return;
         end
         if (attr < NUM_ATTRS) begin
            for (int s = 0; s < stored && s < MAX_SUBS; s++) begin
               if (present[s][attr] && (val < lo_tab[s][attr] || val > hi_tab[s][attr]))
                  falsified[s] = 1'b1;
            end
         end
         if (!last) return;
         if (stored >= MAX_SUBS) live = '1;
         else live = (({{(MAX_SUBS-1){1'b0}}, 1'b1}) << stored) - 1'b1;
         live = ~falsified & live;
         o.kind   = KIND_EVENT;
         o.status = STATUS_OK;
         o.mask   = MASK_W'(live);
         o.count  = COUNT_W'($countones(live));
         falsified = '0;
         due_outcomes = {due_outcomes, o};
      endfunction

      task report(string what);
         errors++;
         if (errors <= 40) $display("mismatch: %s", what);
      endtask

      task check_outcome(outcome_type got);
         outcome_type exp;
         if (due_outcomes.size() == 0) begin
            report($sformatf("result with nothing due: kind %0d mask %h", got.kind, got.mask));
            return;
         end
         exp = due_outcomes.pop_front();
         if (got.kind !== exp.kind)
            report($sformatf("result_kind %0d, want %0d", got.kind, exp.kind));
         if (got.status !== exp.status)
            report($sformatf("status %0d, want %0d", got.status, exp.status));
         if (got.index !== exp.index)
            report($sformatf("sub_index %0d, want %0d", got.index, exp.index));
         if (got.mask !== exp.mask)
            report($sformatf("match_mask %h, want %h", got.mask, exp.mask));
         if (got.count !== exp.count)
            report($sformatf("match_count %0d, want %0d", got.count, exp.count));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_type;
   logic [ATTR_W-1:0]     req_attribute;
   logic [BOUND_W-1:0]    req_low_bound;
   logic [BOUND_W-1:0]    req_high_bound;
   logic [BOUND_W-1:0]    req_event_value;
   logic                  req_last;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_result_kind;
   logic                  rsp_status;
   logic [INDEX_W-1:0]    rsp_sub_index;
   logic [MASK_W-1:0]     rsp_match_mask;
   logic [COUNT_W-1:0]    rsp_match_count;

   interval_book_type subs_book = new();
   int           beats_sent = 0;
   int           idle_cycles = 0;
   logic         calm = 1'b0;
   logic         hold_rsp = 1'b0;
   bit           hold_done = 1'b0;

   interval_subscription_matcher dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_attribute   (req_attribute),
      .req_low_bound   (req_low_bound),
      .req_high_bound  (req_high_bound),
      .req_event_value (req_event_value),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_status      (rsp_status),
      .rsp_sub_index   (rsp_sub_index),
      .rsp_match_mask  (rsp_match_mask),
      .rsp_match_count (rsp_match_count)
   );

   always #6 clock = ~clock;

   function automatic logic [VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return VMAX;
         2, 3:    return VALUE_BITS'($urandom);
         default: return VALUE_BITS'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic offer_beat(logic kind, logic [ATTR_W-1:0] attr, logic [VALUE_BITS-1:0] lo,
                             logic [VALUE_BITS-1:0] hi, logic [VALUE_BITS-1:0] val,
                             logic last);
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_attribute   <= attr;
      req_low_bound   <= lo;
      req_high_bound  <= hi;
      req_event_value <= val;
      req_last        <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      subs_book.absorb_request(kind, attr, lo, hi, val, last);
      beats_sent++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (subs_book.due_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic offer_event(int pairs);
      for (int k = 0; k < pairs; k++)
         offer_beat(KIND_EVENT, ATTR_W'($urandom_range(0, NUM_ATTRS - 1)),
                    VALUE_BITS'($urandom), VALUE_BITS'($urandom), pick_value(), k == pairs - 1);
   endtask

   // response side: random stall bursts plus one long hold-off
   initial begin : rsp_side
      int          quiet_left;
      outcome_type got;
      quiet_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            got.kind   = rsp_result_kind;
            got.status = rsp_status;
            got.index  = rsp_sub_index;
            got.mask   = rsp_match_mask;
            got.count  = rsp_match_count;
            subs_book.check_outcome(got);
         end
         if (hold_rsp && !hold_done) begin
            hold_done  = 1'b1;
            quiet_left = LONG_HOLD;
         end else if (quiet_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
            quiet_left = $urandom_range(1, 8);
         end
         if (quiet_left > 0) begin
            rsp_ready <= 1'b0;
            quiet_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : req_side
      int                    n;
      logic [ATTR_W-1:0]     attr;
      logic [VALUE_BITS-1:0] a;
      logic [VALUE_BITS-1:0] b;
      logic [VALUE_BITS-1:0] lo;
      logic [VALUE_BITS-1:0] hi;
      bit                    paused;
      paused = 1'b0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_type        <= KIND_INSERT;
      req_attribute   <= '0;
      req_low_bound   <= '0;
      req_high_bound  <= '0;
      req_event_value <= '0;
      req_last        <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // event on an empty table, then a few hand-built subscriptions and events against them
      offer_beat(KIND_EVENT,  4'd0,  '0,   VMAX, '0,   1'b1);
      offer_beat(KIND_INSERT, 4'd0,  '0,   VMAX, VMAX, 1'b1);
      offer_beat(KIND_INSERT, 4'd15, VALUE_BITS'(100), VALUE_BITS'(200), '0, 1'b0);
      offer_beat(KIND_INSERT, 4'd15, VALUE_BITS'(150), VALUE_BITS'(300), '0, 1'b1);
      offer_beat(KIND_INSERT, 4'd3,  VALUE_BITS'(500), VALUE_BITS'(400), VMAX, 1'b1);
      offer_beat(KIND_INSERT, 4'd5,  VALUE_BITS'(10),  VALUE_BITS'(20),  '0, 1'b0);
      offer_beat(KIND_EVENT,  4'd15, VMAX, '0,   VALUE_BITS'(150), 1'b0);
      offer_beat(KIND_EVENT,  4'd3,  '0,   '0,   VALUE_BITS'(450), 1'b0);
      offer_beat(KIND_EVENT,  4'd5,  '0,   '0,   '0,   1'b1);
      offer_beat(KIND_INSERT, 4'd0,  VMAX, VMAX, '0,   1'b1);
      offer_beat(KIND_EVENT,  4'd0,  '0,   '0,   VMAX, 1'b0);
      offer_beat(KIND_EVENT,  4'd5,  '0,   '0,   VALUE_BITS'(20),  1'b1);
      offer_beat(KIND_EVENT,  4'd15, '0,   '0,   VALUE_BITS'(201), 1'b0);
      offer_beat(KIND_EVENT,  4'd0,  '0,   '0,   '0,   1'b1);
      offer_beat(KIND_EVENT,  4'd7,  '0,   '0,   VALUE_BITS'(12345), 1'b1);
      offer_beat(KIND_EVENT,  4'd3,  VMAX, VMAX, '0,   1'b1);

      while (beats_sent < BEAT_GOAL) begin
         if (beats_sent >= 200 && !hold_rsp) hold_rsp <= 1'b1;
         if (beats_sent >= 420 && !paused) begin
            paused = 1'b1;
            drain();
         end
         if (beats_sent >= BEAT_GOAL - 140) calm <= 1'b1;
         if ($urandom_range(0, 9) < 4) begin
            n = $urandom_range(1, 4);
            attr = ATTR_W'($urandom_range(0, NUM_ATTRS - 1));
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(0, 2) != 0) attr = ATTR_W'($urandom_range(0, NUM_ATTRS - 1));
               a = pick_value();
               b = pick_value();
               if ($urandom_range(0, 9) == 0) begin
                  lo = (a > b) ? a : b;
                  hi = (a > b) ? b : a;
               end else begin
                  lo = (a < b) ? a : b;
                  hi = (a < b) ? b : a;
               end
               offer_beat(KIND_INSERT, attr, lo, hi, VALUE_BITS'($urandom), k == n - 1);
               if (k < n - 1 && $urandom_range(0, 11) == 0) offer_event($urandom_range(1, 2));
            end
         end else begin
            offer_event($urandom_range(1, 5));
         end
      end

      drain();
      repeat (MAX_SUBS + 16) @(posedge clock);
      if (subs_book.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/ism_pkg.sv
src/ism_head.sv
src/ism_cell.sv
src/interval_subscription_matcher.sv
tb/sv/tb_interval_subscription_matcher.sv
